FILE: rtl/core/sha256_hash_engine_unit_assert.svh
// Assertion macros shared by the SHA-256 engine modules.
// Each macro takes a label, the clock, the active-low reset, the antecedent,
// the consequent and the message text.
`ifndef SHA256_HASH_ENGINE_UNIT_ASSERT_SVH
`define SHA256_HASH_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SHE_ASSERT_IMP(name, clk_s, rst_n_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHE_ASSERT_NXT(name, clk_s, rst_n_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sha_eng_pkg.sv
package sha_eng_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned NIB_W       = 4;
	localparam int unsigned IDX_W       = 3;
	localparam int unsigned LENGTH_BITS = 64;

	typedef enum logic [2:0] {
		PUSH_MSG    = 3'd0,
		PUSH_ONE    = 3'd1,
		PUSH_ZERO   = 3'd2,
		PUSH_LEN_HI = 3'd3,
		PUSH_LEN_LO = 3'd4
	} push_sel_t;

	typedef struct packed {
		logic      push;
		push_sel_t sel;
		logic      load;
		logic      round;
		logic      add;
		logic      shift_out;
		logic      clear;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_len;
		logic round_last;
		logic out_last;
	} dp_status_t;

	localparam logic [WORD_W-1:0] HASH_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

FILE: rtl/core/sha_eng_if.sv
interface sha_eng_msg_if;
	import sha_eng_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] message_word;
	logic [NIB_W-1:0]  nibbles_valid;
	logic              end_of_message;

	modport source(output valid, message_word, nibbles_valid, end_of_message, input ready);
	modport sink(input valid, message_word, nibbles_valid, end_of_message, output ready);
endinterface

interface sha_eng_dig_if;
	import sha_eng_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic [IDX_W-1:0]  digest_index;
	logic              digest_last;

	modport source(output valid, digest_word, digest_index, digest_last, input ready);
	modport sink(input valid, digest_word, digest_index, digest_last, output ready);
endinterface

FILE: rtl/core/sha_eng_ctrl.sv
`include "sha256_hash_engine_unit_assert.svh"

module sha_eng_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_last,
	input  logic [3:0]              in_nibbles,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  sha_eng_pkg::dp_status_t status,
	output sha_eng_pkg::dp_cmd_t    cmd
);
	import sha_eng_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_ADD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		PH_NONE   = 5'b00001,
		PH_ONE    = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_LEN_LO = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_NONE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cmd       = '0;
		cmd.sel   = PUSH_MSG;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.push = 1'b1;
					cmd.sel  = PUSH_MSG;
					if (in_last) begin
						phase_d = in_nibbles[3] ? PH_ONE : PH_ZERO;
					end
					if (status.pos_last) begin
						cmd.load = 1'b1;
						state_d  = ST_ROUND;
					end else if (in_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				unique case (phase_q)
					PH_ONE: begin
						cmd.sel = PUSH_ONE;
						phase_d = PH_ZERO;
					end
					PH_ZERO: begin
						if (status.pos_len) begin
							cmd.sel = PUSH_LEN_HI;
							phase_d = PH_LEN_LO;
						end else begin
							cmd.sel = PUSH_ZERO;
						end
					end
					PH_LEN_LO: begin
						cmd.sel = PUSH_LEN_LO;
						phase_d = PH_DONE;
					end
					default: begin
						cmd.push = 1'b0;
					end
				endcase
				if (cmd.push && status.pos_last) begin
					cmd.load = 1'b1;
					state_d  = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (status.round_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				unique case (phase_q)
					PH_NONE: state_d = ST_IDLE;
					PH_DONE: state_d = ST_OUT;
					default: state_d = ST_PAD;
				endcase
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift_out = 1'b1;
					if (status.out_last) begin
						cmd.clear = 1'b1;
						phase_d   = PH_NONE;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`SHE_ASSERT_IMP(a_no_overlap, clk, arst_n, in_ready, !out_valid, "input and output open together")
	`SHE_ASSERT_NXT(a_load_rounds, clk, arst_n, cmd.load, state_q == ST_ROUND, "block load without rounds")
	`SHE_ASSERT_NXT(a_round_end, clk, arst_n, state_q == ST_ROUND && status.round_last, state_q == ST_ADD, "rounds did not end in add")

endmodule

FILE: rtl/core/sha_eng_dp.sv
`include "sha256_hash_engine_unit_assert.svh"

module sha_eng_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sha_eng_pkg::dp_cmd_t                  cmd,
	input  logic [sha_eng_pkg::WORD_W-1:0]        message_word,
	input  logic [sha_eng_pkg::NIB_W-1:0]         nibbles_valid,
	input  logic                                  end_of_message,
	output sha_eng_pkg::dp_status_t               status,
	output logic [sha_eng_pkg::WORD_W-1:0]        digest_word,
	output logic [sha_eng_pkg::IDX_W-1:0]         digest_index,
	output logic                                  digest_last
);
	import sha_eng_pkg::*;

	function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] small_sig0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] small_sig1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	logic [WORD_W-1:0]      win_q   [0:15];
	logic [WORD_W-1:0]      chain_q [0:7];
	logic [WORD_W-1:0]      var_q   [0:7];
	logic [LENGTH_BITS-1:0] bit_count_q;
	logic [3:0]             pos_q;
	logic [5:0]             round_q;
	logic [IDX_W-1:0]       out_idx_q;

	logic [NIB_W-1:0]  nib_c;
	logic [5:0]        shamt;
	logic [WORD_W-1:0] keep;
	logic [WORD_W-1:0] msg_w;
	logic [WORD_W-1:0] push_w;
	logic [63:0]       len_w;
	logic [5:0]        add_bits;
	logic [WORD_W-1:0] sched_w;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] ch;
	logic [WORD_W-1:0] mj;

	assign nib_c    = nibbles_valid[3] ? 4'd8 : nibbles_valid;
	assign shamt    = {nib_c, 2'b00};
	assign keep     = ~(32'hffffffff >> shamt);
	assign msg_w    = (end_of_message && !nib_c[3])
		? ((message_word & keep) | (32'h80000000 >> shamt)) : message_word;
	assign len_w    = 64'(bit_count_q);
	assign add_bits = end_of_message ? {nib_c, 2'b00} : 6'd32;

	always_comb begin
		unique case (cmd.sel)
			PUSH_MSG:    push_w = msg_w;
			PUSH_ONE:    push_w = 32'h80000000;
			PUSH_ZERO:   push_w = '0;
			PUSH_LEN_HI: push_w = len_w[63:32];
			PUSH_LEN_LO: push_w = len_w[31:0];
			default:     push_w = '0;
		endcase
	end

	assign sched_w = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];
	assign ch      = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign mj      = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1      = var_q[7] + big_sig1(var_q[4]) + ch + ROUND_K[round_q] + win_q[0];
	assign t2      = big_sig0(var_q[0]) + mj;

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= cmd.push ? push_w : sched_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= HASH_IV[i];
				var_q[i]   <= '0;
			end
			bit_count_q <= '0;
			pos_q       <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 4'd1;
			end
			if (cmd.clear) begin
				bit_count_q <= '0;
			end else if (cmd.push && cmd.sel == PUSH_MSG) begin
				bit_count_q <= bit_count_q + LENGTH_BITS'(add_bits);
			end
			if (cmd.load) begin
				for (int i = 0; i < 8; i++) begin
					var_q[i] <= chain_q[i];
				end
				round_q <= '0;
			end else if (cmd.round) begin
				for (int i = 1; i < 8; i++) begin
					var_q[i] <= var_q[i-1];
				end
				var_q[4] <= var_q[3] + t1;
				var_q[0] <= t1 + t2;
				round_q  <= round_q + 6'd1;
			end
			if (cmd.clear) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= HASH_IV[i];
				end
			end else if (cmd.add) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + var_q[i];
				end
			end else if (cmd.shift_out) begin
				for (int i = 0; i < 7; i++) begin
					chain_q[i] <= chain_q[i+1];
				end
				chain_q[7] <= chain_q[0];
			end
			if (cmd.shift_out) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
		end
	end

	assign status.pos_last   = (pos_q == 4'd15);
	assign status.pos_len    = (pos_q == 4'd14);
	assign status.round_last = (round_q == 6'd63);
	assign status.out_last   = (out_idx_q == 3'd7);

	assign digest_word  = chain_q[0];
	assign digest_index = out_idx_q;
	assign digest_last  = (out_idx_q == 3'd7);

	`SHE_ASSERT_IMP(a_cmd_excl, clk, arst_n, cmd.round, !cmd.push && !cmd.add && !cmd.load, "round overlaps another command")
	`SHE_ASSERT_IMP(a_len_slot, clk, arst_n, cmd.push && cmd.sel == PUSH_LEN_LO, pos_q == 4'd15, "length word off its slot")
	`SHE_ASSERT_NXT(a_load_cnt, clk, arst_n, cmd.load, round_q == 6'd0, "round count not cleared by load")

endmodule

FILE: rtl/core/sha256_hash_engine_unit.sv
// SHA-256 engine for messages given as big-endian 32-bit words, the last word
// carrying a count of valid leading nibbles. Words are taken while the engine is
// idle; every sixteenth word of a block starts the compression, which holds the
// input off for 64 rounds on the single round unit and then a chaining add.
// After the final word the engine inserts the padding and length words at one
// per cycle, with a compression between them when a block fills, runs one or two
// more compressions, and then offers the eight digest words h0 to h7 as eight
// output transfers; only after the last of them does it take the first word of
// the next message.

module sha256_hash_engine_unit (
	input logic           clk,
	input logic           arst_n,
	sha_eng_msg_if.sink   message,
	sha_eng_dig_if.source digest
);
	import sha_eng_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	sha_eng_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (message.valid),
		.in_last    (message.end_of_message),
		.in_nibbles (message.nibbles_valid),
		.in_ready   (message.ready),
		.out_valid  (digest.valid),
		.out_ready  (digest.ready),
		.status     (status),
		.cmd        (cmd)
	);

	sha_eng_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.message_word   (message.message_word),
		.nibbles_valid  (message.nibbles_valid),
		.end_of_message (message.end_of_message),
		.status         (status),
		.digest_word    (digest.digest_word),
		.digest_index   (digest.digest_index),
		.digest_last    (digest.digest_last)
	);

endmodule
